[design/rmva_pkg.sv]
// ----------------------------------------------------------------------------
// rmva_pkg: shared types and constants for the running mean/variance block
// fixed-point widths, beat structs and the default store depth
// ----------------------------------------------------------------------------
package rmva_pkg;

    localparam int unsigned ENTRIES_DEF = 4096;
    localparam int unsigned IDX_W       = 12;
    localparam int unsigned TRIAL_W     = 16;
    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned MEAN_W      = 48;
    localparam int unsigned VAR_W       = 64;
    localparam int unsigned NS_W        = 16;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned PROD_W      = 2 * MEAN_W;

    typedef struct packed {
        logic [IDX_W-1:0]    entry_index;
        logic [TRIAL_W-1:0]  trial_index;
        logic [SAMPLE_W-1:0] sample_value;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_W-1:0]  entry_echo;
        logic [MEAN_W-1:0] mean_value;
        logic [VAR_W-1:0]  variance_sum;
    } t_out_beat;

endpackage

[design/rmva_divider.sv]
// ----------------------------------------------------------------------------
// rmva_divider: pipelined restoring divider
// one quotient bit per stage; while i_en is high a new division may enter every cycle
// ----------------------------------------------------------------------------
module rmva_divider
    import rmva_pkg::*;
#(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 17,
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [NUM_W-1:0] o_quo,
    output logic [TAG_W-1:0] o_tag
);

    logic [NUM_W:0]           r_vld;
    logic [NUM_W-1:0]         r_num [NUM_W+1];
    logic [DEN_W:0]           r_rem [NUM_W+1];
    logic [DEN_W-1:0]         r_den [NUM_W+1];
    logic [TAG_W-1:0]         r_tag [NUM_W+1];

    // per-stage trial subtraction
    logic [DEN_W+1:0]         trial [NUM_W];
    logic [DEN_W+1:0]         diff  [NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NUM_W-1:0], i_valid};
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_W; s++) begin
            trial[s] = {r_rem[s], r_num[s][NUM_W-1]};
            diff[s]  = trial[s] - {2'b00, r_den[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num;
            r_rem[0] <= '0;
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            for (int s = 0; s < NUM_W; s++) begin
                r_den[s+1] <= r_den[s];
                r_tag[s+1] <= r_tag[s];
                if (!diff[s][DEN_W+1]) begin
                    r_rem[s+1] <= diff[s][DEN_W:0];
                    r_num[s+1] <= {r_num[s][NUM_W-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= trial[s][DEN_W:0];
                    r_num[s+1] <= {r_num[s][NUM_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_num[NUM_W];
    assign o_tag   = r_tag[NUM_W];

endmodule

[design/running_mean_variance_accumulator.sv]
// ----------------------------------------------------------------------------
// running_mean_variance_accumulator: per-entry welford mean and variance sum
// reads an entry, updates mean and variance sum, writes back in-range entries, returns both
// ----------------------------------------------------------------------------
// path: two pipelined restoring divider stages (49 and 81 register stages)
// plus six other stages (a, b, c, d, e and the output register)
// throughput: one beat per cycle when entries differ and the skid register is
// empty; a beat whose entry is still in the busy list waits at the input
// reset: synchronous active low; a clearing pass over every entry zeroes
// the stores with the input held off, num_samples returns to 1
module running_mean_variance_accumulator
    import rmva_pkg::*;
#(
    parameter int unsigned ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [NS_W-1:0] i_cfg_data,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    localparam int unsigned AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned DEN1  = TRIAL_W + 1;
    localparam int unsigned QT_W  = PROD_W - FRAC_W;     // 80 bit term quotient
    localparam int unsigned TAG1  = IDX_W + 1 + 1 + MEAN_W + MEAN_W + MEAN_W;
    localparam int unsigned TAG2  = IDX_W + 1 + MEAN_W + VAR_W;
    localparam int unsigned DEPTH = 8 + MEAN_W + QT_W + 8;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    // state stores, read registered
    logic [MEAN_W-1:0] r_mem_m [ENTRIES];
    logic [VAR_W-1:0]  r_mem_v [ENTRIES];

    logic [NS_W-1:0] r_ns;
    logic [AW:0]     r_clr;
    logic            clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ns <= NS_W'(1);
        end else if (i_cfg_we) begin
            r_ns <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (clearing) begin
            r_clr <= r_clr + (AW+1)'(1);
        end
    end
    assign clearing = (r_clr < (AW+1)'(ENTRIES));

    // pipeline enable: every stage up to writeback moves unless the skid register holds a beat
    logic en;
    logic r_ov;
    logic r_sk_v;
    assign en = !r_sk_v;

    // in-flight bookkeeping: hazard by entry, count for output space
    logic [DEPTH-1:0] r_busy_v;
    logic [IDX_W-1:0] r_busy_i [DEPTH];
    logic hazard;
    logic [CW-1:0] r_cnt;
    logic          room;

    always_comb begin
        hazard = 1'b0;
        for (int k = 0; k < DEPTH; k++) begin
            if (r_busy_v[k] && r_busy_i[k] == i_data.entry_index) hazard = 1'b1;
        end
    end

    assign room    = (r_cnt < CW'(DEPTH));
    assign o_ready = en && !clearing && !hazard && room;

    logic acc;
    assign acc = i_valid && o_ready;

    logic done_now;
    logic s_wb;   // writeback stage valid
    assign done_now = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CW'(acc) - CW'(done_now);
        end
    end

    // stage a: memory read
    logic              r_a_v;
    logic [IDX_W-1:0]  r_a_idx;
    logic              r_a_in;
    logic [TRIAL_W-1:0] r_a_tr;
    logic [SAMPLE_W-1:0] r_a_x;
    logic [MEAN_W-1:0] r_a_m;
    logic [VAR_W-1:0]  r_a_vv;
    logic              in_rng;
    logic [AW-1:0]     rd_addr;
    assign in_rng  = ({5'd0, i_data.entry_index} < (IDX_W+5)'(ENTRIES));
    assign rd_addr = AW'(i_data.entry_index);

    // writeback signals
    logic [IDX_W-1:0]  wb_idx;
    logic              wb_in;
    logic [MEAN_W-1:0] wb_m;
    logic [VAR_W-1:0]  wb_v;
    logic [AW-1:0]     wr_addr;
    assign wr_addr = AW'(wb_idx);

    always_ff @(posedge i_clk) begin
        if (clearing) begin
            r_mem_m[r_clr[AW-1:0]] <= '0;
            r_mem_v[r_clr[AW-1:0]] <= '0;
        end else if (s_wb && en && wb_in) begin
            r_mem_m[wr_addr] <= wb_m;
            r_mem_v[wr_addr] <= wb_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_m  <= r_mem_m[rd_addr];
            r_a_vv <= r_mem_v[rd_addr];
            r_a_idx <= i_data.entry_index;
            r_a_in  <= in_rng;
            r_a_tr  <= i_data.trial_index;
            r_a_x   <= i_data.sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (en) begin
            r_a_v <= acc;
        end
    end

    // stage b: difference x - m
    logic              r_b_v;
    logic [IDX_W-1:0]  r_b_idx;
    logic              r_b_in, r_b_neg;
    logic [MEAN_W-1:0] r_b_m, r_b_x, r_b_d;
    logic [DEN1-1:0]   r_b_n1;
    logic [VAR_W-1:0]  r_b_vv;
    logic [MEAN_W-1:0] xq_a, m_a;

    assign xq_a = {r_a_x, 16'd0};
    assign m_a  = r_a_in ? r_a_m : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (en) begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_idx <= r_a_idx;
            r_b_in  <= r_a_in;
            r_b_neg <= xq_a < m_a;
            r_b_d   <= (xq_a < m_a) ? m_a - xq_a : xq_a - m_a;
            r_b_m   <= m_a;
            r_b_x   <= xq_a;
            r_b_n1  <= {1'b0, r_a_tr} + DEN1'(1);
            r_b_vv  <= r_a_in ? r_a_vv : '0;
        end
    end

    // first divider: |d| / (n + 1); variance read travels in a side line
    logic              d1_v;
    logic [MEAN_W-1:0] d1_q;
    logic [TAG1-1:0]   d1_t;
    logic [VAR_W-1:0]  r_vline [MEAN_W+1+1];

    rmva_divider #(.NUM_W(MEAN_W), .DEN_W(DEN1), .TAG_W(TAG1)) u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_v),
        .i_num   (r_b_d),
        .i_den   (r_b_n1),
        .i_tag   ({r_b_idx, r_b_in, r_b_neg, r_b_m, r_b_x, r_b_d}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_tag   (d1_t)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vline[0] <= r_b_vv;
            for (int k = 1; k <= MEAN_W + 1; k++) r_vline[k] <= r_vline[k-1];
        end
    end

    // stage c: new mean and second difference
    logic [IDX_W-1:0]  t1_idx;
    logic              t1_in, t1_neg;
    logic [MEAN_W-1:0] t1_m, t1_x, t1_d, mnew;
    assign {t1_idx, t1_in, t1_neg, t1_m, t1_x, t1_d} = d1_t;
    assign mnew = t1_neg ? t1_m - d1_q : t1_m + d1_q;

    logic              r_c_v;
    logic [IDX_W-1:0]  r_c_idx;
    logic              r_c_in;
    logic [MEAN_W-1:0] r_c_mn, r_c_d, r_c_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (en) begin
            r_c_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_idx <= t1_idx;
            r_c_in  <= t1_in;
            r_c_mn  <= mnew;
            r_c_d   <= t1_d;
            r_c_d2  <= (t1_x < mnew) ? mnew - t1_x : t1_x - mnew;
        end
    end

    // stages d/e: 48x48 product as four 24x24 partial products, then sum
    logic              r_d_v, r_e_v;
    logic [IDX_W-1:0]  r_d_idx, r_e_idx;
    logic              r_d_in, r_e_in;
    logic [MEAN_W-1:0] r_d_mn, r_e_mn;
    logic [47:0]       r_pll, r_plh, r_phl, r_phh;
    logic [PROD_W-1:0] r_e_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (en) begin
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_idx <= r_c_idx;
            r_d_in  <= r_c_in;
            r_d_mn  <= r_c_mn;
            r_pll   <= r_c_d[23:0]  * r_c_d2[23:0];
            r_plh   <= r_c_d[23:0]  * r_c_d2[47:24];
            r_phl   <= r_c_d[47:24] * r_c_d2[23:0];
            r_phh   <= r_c_d[47:24] * r_c_d2[47:24];
            r_e_idx <= r_d_idx;
            r_e_in  <= r_d_in;
            r_e_mn  <= r_d_mn;
            r_e_p   <= {48'd0, r_pll} + {24'd0, r_plh, 24'd0}
                     + {24'd0, r_phl, 24'd0} + {r_phh, 48'd0};
        end
    end

    // second divider: floor(product / 2^16) / num_samples, zero acting as one
    logic [NS_W:0] den2;
    assign den2 = (r_ns == '0) ? (NS_W+1)'(1) : {1'b0, r_ns};

    logic              d2_v;
    logic [QT_W-1:0]   d2_q;
    logic [TAG2-1:0]   d2_t;
    logic [VAR_W-1:0]  r_vline2 [2];

    // side line brings the variance read level with stage e
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vline2[0] <= r_vline[MEAN_W+1];
            r_vline2[1] <= r_vline2[0];
        end
    end

    rmva_divider #(.NUM_W(QT_W), .DEN_W(NS_W+1), .TAG_W(TAG2)) u_div_var (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_e_v),
        .i_num   (r_e_p[PROD_W-1:FRAC_W]),
        .i_den   (den2),
        .i_tag   ({r_e_idx, r_e_in, r_e_mn, r_vline2[1]}),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_tag   (d2_t)
    );

    // stage f: saturating add, writeback, output register and skid
    logic [VAR_W-1:0] t2_v;
    logic [VAR_W:0]   vsum;
    t_out_beat        wb_beat;
    t_out_beat        r_sk_d;
    assign {wb_idx, wb_in, wb_m, t2_v} = d2_t;
    assign s_wb = d2_v;
    assign vsum = {1'b0, t2_v} + {1'b0, d2_q[VAR_W-1:0]};
    assign wb_v = (d2_q[QT_W-1:VAR_W] != '0 || vsum[VAR_W]) ? '1 : vsum[VAR_W-1:0];
    assign wb_beat = {wb_idx, wb_m, wb_v};

    // the skid catches the beat leaving the pipeline while the output waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (!r_ov || done_now) begin
            if (r_sk_v) begin
                r_ov   <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_ov <= s_wb;
            end
        end else if (s_wb && en) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || done_now) begin
            o_data <= r_sk_v ? r_sk_d : wb_beat;
        end
        if (r_ov && !done_now && en) begin
            r_sk_d <= wb_beat;
        end
    end
    assign o_valid = r_ov;

    // busy list shifts with the pipeline; entries drop after DEPTH shifts, past writeback
    logic [IDX_W-1:0] r_bq_i [DEPTH];
    logic [DEPTH-1:0] r_bq_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bq_v <= '0;
        end else if (en) begin
            r_bq_v <= {r_bq_v[DEPTH-2:0], acc};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bq_i[0] <= i_data.entry_index;
            for (int k = 1; k < DEPTH; k++) r_bq_i[k] <= r_bq_i[k-1];
        end
    end
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            r_busy_v[k] = r_bq_v[k];
            r_busy_i[k] = r_bq_i[k];
        end
    end

endmodule

[verif/tb_running_mean_variance_accumulator.sv]
// ----------------------------------------------------------------------------
// tb_running_mean_variance_accumulator: self-checking bench for the welford block
// directed table then random beats, predicted by an in-bench mean/variance model
// ----------------------------------------------------------------------------
module tb_running_mean_variance_accumulator;
    import rmva_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned N_ENTRIES = ENTRIES_DEF;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 10;

    // directed row: beat plus an optional hand-typed expectation
    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_dir_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic [NS_W-1:0] i_cfg_data;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    // predictor state: its own copy of the stores and the divisor
    logic [MEAN_W-1:0] mean_mirror [N_ENTRIES];
    logic [VAR_W-1:0]  varsum_mirror [N_ENTRIES];
    logic [NS_W-1:0]   divisor_reg;

    t_out_beat stats_pending [$];
    int unsigned mismatches;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    running_mean_variance_accumulator #(
        .ENTRIES(N_ENTRIES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // welford update on the mirror; returns the beat the block should produce
    function automatic t_out_beat welford_update(t_in_beat b);
        logic [MEAN_W-1:0]   m;
        logic [VAR_W-1:0]    v;
        logic [MEAN_W-1:0]   xq;
        logic [MEAN_W-1:0]   d_mag;
        logic [MEAN_W-1:0]   d2_mag;
        logic [MEAN_W-1:0]   mnew;
        logic [16:0]         n1;
        logic [PROD_W-1:0]   prod;
        logic [PROD_W-1:0]   term;
        logic [VAR_W:0]      vsum;
        logic [NS_W-1:0]     div;
        bit                  d_neg;
        bit                  d2_neg;
        bit                  in_range;
        t_out_beat           r;
        in_range = b.entry_index < N_ENTRIES;
        m = in_range ? mean_mirror[b.entry_index] : '0;
        v = in_range ? varsum_mirror[b.entry_index] : '0;
        div = (divisor_reg == 0) ? NS_W'(1) : divisor_reg;
        n1 = {1'b0, b.trial_index} + 17'd1;
        xq = {b.sample_value, 16'h0};
        d_neg = xq < m;
        d_mag = d_neg ? m - xq : xq - m;
        mnew = d_neg ? m - d_mag / n1 : m + d_mag / n1;
        d2_neg = xq < mnew;
        d2_mag = d2_neg ? mnew - xq : xq - mnew;
        // opposite signs cannot really occur, but the rule is kept
        if (d_neg != d2_neg && d_mag != 0 && d2_mag != 0)
            term = '0;
        else begin
            prod = PROD_W'(d_mag) * PROD_W'(d2_mag);
            term = (prod >> FRAC_W) / div;
        end
        if (term[PROD_W-1:VAR_W] != 0)
            vsum = {1'b1, {VAR_W{1'b1}}};
        else
            vsum = {1'b0, v} + {1'b0, term[VAR_W-1:0]};
        if (vsum[VAR_W])
            vsum[VAR_W-1:0] = '1;
        if (in_range) begin
            mean_mirror[b.entry_index] = mnew;
            varsum_mirror[b.entry_index] = vsum[VAR_W-1:0];
        end
        r.entry_echo = b.entry_index;
        r.mean_value = mnew;
        r.variance_sum = vsum[VAR_W-1:0];
        return r;
    endfunction

    // result side: random stall, compare every accepted beat to the oldest expectation
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (stats_pending.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result beat %h", o_data);
                end else begin
                    t_out_beat want;
                    want = stats_pending.pop_front();
                    if (o_data.entry_echo !== want.entry_echo
                        || o_data.mean_value !== want.mean_value
                        || o_data.variance_sum !== want.variance_sum) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: exp entry %h mean %h var %h, got %h %h %h",
                                     want.entry_echo, want.mean_value, want.variance_sum,
                                     o_data.entry_echo, o_data.mean_value,
                                     o_data.variance_sum);
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // hold valid with a fixed payload until the beat is taken
    task automatic send_beat(t_in_beat b, bit typed, t_out_beat typed_want);
        t_out_beat want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        want = welford_update(b);
        if (typed && want !== typed_want) begin
            // a typed row disagreeing with the predictor is a bench fault
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("typed row %h disagrees with predictor %h", typed_want, want);
        end
        stats_pending.insert(stats_pending.size(), typed ? typed_want : want);
    endtask

    // wait out every expected beat and a further drain margin before touching config
    task automatic drain_all();
        i_valid <= 1'b0;
        while (stats_pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_divisor(logic [NS_W-1:0] val);
        drain_all();
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        divisor_reg = val;
    endtask

    function automatic t_in_beat rand_beat(int unsigned entry_span);
        t_in_beat b;
        b.entry_index = IDX_W'($urandom_range(entry_span));
        b.trial_index = TRIAL_W'($urandom_range(3) == 0 ? $urandom_range(65534)
                                                          : $urandom_range(40));
        case ($urandom_range(5))
            0: b.sample_value = $urandom();
            1: b.sample_value = 32'hFFFF_FFFF - $urandom_range(3);
            2: b.sample_value = $urandom_range(3);
            default: b.sample_value = $urandom_range(5000);
        endcase
        return b;
    endfunction

    t_dir_row dir_rows [$];

    function automatic void queue_row(t_dir_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic t_dir_row mk_row(logic [IDX_W-1:0] e, logic [TRIAL_W-1:0] t,
                                        logic [SAMPLE_W-1:0] x, bit typed,
                                        logic [MEAN_W-1:0] em, logic [VAR_W-1:0] ev);
        t_dir_row r;
        r.beat = '{entry_index: e, trial_index: t, sample_value: x};
        r.typed = typed;
        r.want = '{entry_echo: e, mean_value: em, variance_sum: ev};
        return r;
    endfunction

    initial begin
        int unsigned phase;
        t_in_beat    b;
        t_out_beat   none;
        none = '0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_data = '0;
        mismatches = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        divisor_reg = NS_W'(1);
        foreach (mean_mirror[k]) begin
            mean_mirror[k] = '0;
            varsum_mirror[k] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first sample on a cleared entry: mean is x, no variance yet
        queue_row(mk_row(12'd0, 16'd0, 32'd0, 1'b1, 48'd0, 64'd0));
        queue_row(mk_row(12'd4095, 16'd0, 32'hFFFF_FFFF, 1'b1,
                         48'hFFFF_FFFF_0000, 64'd0));
        queue_row(mk_row(12'd1, 16'd0, 32'd10, 1'b1, 48'h000A_0000, 64'd0));
        // second trial on the same entries
        queue_row(mk_row(12'd1, 16'd1, 32'd20, 1'b0, 0, 0));
        queue_row(mk_row(12'd4095, 16'd1, 32'd0, 1'b0, 0, 0));
        queue_row(mk_row(12'd0, 16'd1, 32'hFFFF_FFFF, 1'b0, 0, 0));
        // huge trial number, tiny update step
        queue_row(mk_row(12'd2, 16'd65534, 32'hFFFF_FFFF, 1'b0, 0, 0));
        queue_row(mk_row(12'd1, 16'd65534, 32'd0, 1'b0, 0, 0));
        // sample moving down from mean
        queue_row(mk_row(12'd1, 16'd2, 32'd3, 1'b0, 0, 0));
        queue_row(mk_row(12'd2, 16'd1, 32'd0, 1'b0, 0, 0));
        queue_row(mk_row(12'hAAA, 16'hAAAA, 32'hAAAA_AAAA, 1'b0, 0, 0));
        queue_row(mk_row(12'h555, 16'h5555, 32'h5555_5555, 1'b0, 0, 0));
        queue_row(mk_row(12'hAAA, 16'h5555, 32'h5555_5555, 1'b0, 0, 0));

        foreach (dir_rows[k])
            send_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].want);

        // divisor extremes, zero acts as one
        write_divisor(NS_W'(0));
        b = '{entry_index: 12'd0, trial_index: 16'd2, sample_value: 32'd7};
        send_beat(b, 1'b0, none);
        write_divisor(NS_W'(65535));
        b = '{entry_index: 12'd0, trial_index: 16'd3, sample_value: 32'hFFFF_FFFF};
        send_beat(b, 1'b0, none);
        write_divisor(NS_W'(1));
        // big swings to push the variance sum into saturation
        for (int k = 0; k < 6; k++) begin
            b = '{entry_index: 12'd5, trial_index: TRIAL_W'(k),
                  sample_value: k[0] ? 32'hFFFF_FFFF : 32'd0};
            send_beat(b, 1'b0, none);
        end

        // random phases: sender/receiver idling swaps, then none; divisor per phase
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 59 : 0;
            recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 24 : 0;
            write_divisor(phase == 0 ? NS_W'($urandom_range(1, 16))
                          : phase == 1 ? NS_W'(65535) : NS_W'($urandom()));
            for (int k = 0; k < 180; k++) begin
                // mostly a small set of entries so statistics build up
                b = rand_beat($urandom_range(3) == 0 ? 4095 : 15);
                send_beat(b, 1'b0, none);
                // hold off once until every expected beat is back
                if (phase == 2 && k == 90) begin
                    i_valid <= 1'b0;
                    while (stats_pending.size() != 0) @(posedge i_clk);
                end
            end
        end

        drain_all();
        if (mismatches == 0 && stats_pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // generous ceiling: reset sweep plus ~560 beats plus stalls
    initial begin
        #(8ns * 2_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
design/rmva_pkg.sv
design/rmva_divider.sv
design/running_mean_variance_accumulator.sv
verif/tb_running_mean_variance_accumulator.sv
